/* src/sbc_pkg.sv */
`default_nettype none

package sbc_pkg;

    // ease table
    localparam int EASE_TABLE_BITS = 10;
    localparam int EASE_N          = 1 << EASE_TABLE_BITS;
    localparam int IDX_W           = EASE_TABLE_BITS + 1;

    localparam logic [31:0] PI_Q30  = 32'd3373259426;
    localparam logic [31:0] ONE_Q30 = 32'd1073741824;

    // stream widths
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;

    // config port
    localparam int          CFG_ADDR_W     = 4;
    localparam logic [1:0]  CFG_IDX_ENABLE = 2'd0;
    localparam logic [1:0]  CFG_IDX_DAY    = 2'd1;
    localparam logic [1:0]  CFG_IDX_NIGHT  = 2'd2;
    localparam logic [15:0] DAY_GAIN_RST   = 16'd36045;
    localparam logic [15:0] NIGHT_GAIN_RST = 16'd9175;

    // severity codes
    localparam logic [2:0] SEV_WARN   = 3'd2;
    localparam logic [2:0] SEV_ALERT  = 3'd3;
    localparam logic [2:0] SEV_TAMPER = 3'd4;

    // period class
    localparam logic [1:0] CLS_ALERT = 2'd0;
    localparam logic [1:0] CLS_WARN  = 2'd1;
    localparam logic [1:0] CLS_CALM  = 2'd2;

    localparam int HALF_W = 11;
    localparam int MOD_W  = 13;

    localparam logic [HALF_W-1:0] HALF_ALERT = 11'd1100;
    localparam logic [HALF_W-1:0] HALF_WARN  = 11'd1250;
    localparam logic [HALF_W-1:0] HALF_CALM  = 11'd1400;

    localparam logic [MOD_W-1:0] FULL_ALERT = 13'd2200;
    localparam logic [MOD_W-1:0] FULL_WARN  = 13'd2500;
    localparam logic [MOD_W-1:0] FULL_CALM  = 13'd2800;

    // time mod full period: q ~ now * floor(2^43 / P) >> 43, off by at most one
    localparam int MOD_SHIFT = 43;
    localparam logic [31:0] MOD_RECIP_ALERT = 32'((64'd1 << MOD_SHIFT) / 64'(FULL_ALERT));
    localparam logic [31:0] MOD_RECIP_WARN  = 32'((64'd1 << MOD_SHIFT) / 64'(FULL_WARN));
    localparam logic [31:0] MOD_RECIP_CALM  = 32'((64'd1 << MOD_SHIFT) / 64'(FULL_CALM));

    // index = floor(t * 2^B / h) = (t * ceil(2^(22+B) / h)) >> 22, exact for t <= h
    localparam int IDX_SHIFT   = 22;
    localparam int IDX_RECIP_W = EASE_TABLE_BITS + 12;
    localparam int IDX_PROD_W  = HALF_W + IDX_RECIP_W;
    localparam logic [IDX_RECIP_W-1:0] IDX_RECIP_ALERT = IDX_RECIP_W'(
        ((64'd1 << (IDX_SHIFT + EASE_TABLE_BITS)) + 64'(HALF_ALERT) - 64'd1) / 64'(HALF_ALERT));
    localparam logic [IDX_RECIP_W-1:0] IDX_RECIP_WARN = IDX_RECIP_W'(
        ((64'd1 << (IDX_SHIFT + EASE_TABLE_BITS)) + 64'(HALF_WARN) - 64'd1) / 64'(HALF_WARN));
    localparam logic [IDX_RECIP_W-1:0] IDX_RECIP_CALM = IDX_RECIP_W'(
        ((64'd1 << (IDX_SHIFT + EASE_TABLE_BITS)) + 64'(HALF_CALM) - 64'd1) / 64'(HALF_CALM));

    // breath floor, Q0.16, and its complement
    localparam logic [15:0] FLOOR_ATTN     = 16'd22938;
    localparam logic [15:0] FLOOR_CALM     = 16'd36045;
    localparam logic [15:0] FLOOR_ATTN_INV = 16'd42598;
    localparam logic [15:0] FLOOR_CALM_INV = 16'd29491;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    localparam rgb_t HUE_DAY_WARN    = '{red: 8'hFB, green: 8'h8C, blue: 8'h00};
    localparam rgb_t HUE_DAY_ALERT   = '{red: 8'hE5, green: 8'h39, blue: 8'h35};
    localparam rgb_t HUE_DAY_CALM    = '{red: 8'h43, green: 8'hA0, blue: 8'h47};
    localparam rgb_t HUE_NIGHT_ALERT = '{red: 8'h99, green: 8'h22, blue: 8'h19};
    localparam rgb_t HUE_NIGHT_CALM  = '{red: 8'h5A, green: 8'h1C, blue: 8'h12};

    typedef struct packed {
        logic        enable;
        logic [15:0] day_gain;
        logic [15:0] night_gain;
    } cfg_t;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [2:0]  severity;
        logic        night;
        logic        blackout;
        logic        force_off;
    } tick_t;

    typedef struct packed {
        logic        black;
        logic        attn;
        logic [15:0] peak;
        rgb_t        hue;
    } side_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        side_t            side;
    } phase_t;

    typedef struct packed {
        logic [15:0] ease;
        side_t       side;
    } ease_t;

    function automatic logic [MOD_W-1:0] full_period(input logic [1:0] cls);
        case (cls)
            CLS_ALERT: return FULL_ALERT;
            CLS_WARN:  return FULL_WARN;
            default:   return FULL_CALM;
        endcase
    endfunction

    function automatic logic [HALF_W-1:0] half_period(input logic [1:0] cls);
        case (cls)
            CLS_ALERT: return HALF_ALERT;
            CLS_WARN:  return HALF_WARN;
            default:   return HALF_CALM;
        endcase
    endfunction

    function automatic logic [31:0] mod_recip(input logic [1:0] cls);
        case (cls)
            CLS_ALERT: return MOD_RECIP_ALERT;
            CLS_WARN:  return MOD_RECIP_WARN;
            default:   return MOD_RECIP_CALM;
        endcase
    endfunction

    function automatic logic [IDX_RECIP_W-1:0] idx_recip(input logic [1:0] cls);
        case (cls)
            CLS_ALERT: return IDX_RECIP_ALERT;
            CLS_WARN:  return IDX_RECIP_WARN;
            default:   return IDX_RECIP_CALM;
        endcase
    endfunction

    // (1 - cos(pi * j / N)) / 2 in Q0.16, Taylor series in Q2.30; elaboration only
    function automatic logic [15:0] half_ease(input int unsigned j);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] c;
        logic [63:0] v;
        int unsigned k;
        x    = (64'(PI_Q30) * 64'(j)) >> EASE_TABLE_BITS;
        x2   = (x * x) >> 30;
        term = 64'(ONE_Q30);
        pos  = 64'(ONE_Q30);
        neg  = 64'd0;
        for (k = 1; k <= 10; k++)
        begin
            term = (term * x2) >> 30;
            term = term / 64'((2 * k - 1) * (2 * k));
            if (k[0])
                neg = neg + term;
            else
                pos = pos + term;
        end
        c = (pos > neg) ? pos - neg : 64'd0;
        if (c > 64'(ONE_Q30))
            c = 64'(ONE_Q30);
        v = (64'(ONE_Q30) - c + 64'd16384) >> 15;
        return v[15:0];
    endfunction

    function automatic logic [15:0] ease_value(input int unsigned i);
        logic [16:0] v;
        if (2 * i <= EASE_N)
            return half_ease(i);
        v = 17'd65536 - 17'(half_ease(EASE_N - i));
        return (v > 17'd65535) ? 16'hFFFF : v[15:0];
    endfunction

endpackage

`default_nettype wire

/* src/severity_led_breath_color.sv */
`default_nettype none

// Breathing status LED color generator.
// Input stream s_*: one request per tick carrying the millisecond time, the
// severity and the night / blackout / force-off flags. Output stream m_*:
// one RGB color per request while the enable register is set; requests taken
// while enable is clear produce nothing. Blackout or force-off give black.
// APB port: enable at 0x0, day_gain at 0x4, night_gain at 0x8; write only
// while no request is in flight.
// The pipeline has 8 register stages: four phase stages (coarse quotient
// multiply, remainder, triangle fold, index multiply), one registered ease ROM
// read and three level stages (share, level, channel multiplies). Throughput is
// one request per cycle while m_tready does not stall the output.
// Reset empties the pipeline and loads the register defaults (enable clear).
// A stalled m_tready holds the output; upstream stages keep accepting until
// their bubbles fill, and s_tready drops only when every stage is occupied.
module severity_led_breath_color (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sbc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // now_ms[31:0], severity[34:32], night[35], blackout[36], force_off[37], zero[39:38]
    input  logic [sbc_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // red[7:0], green[15:8], blue[23:16]
    output logic [sbc_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import sbc_pkg::*;

    cfg_t   cfg;
    tick_t  tick;
    logic   ph_valid;
    logic   ph_ready;
    phase_t ph_data;
    logic   ease_valid;
    logic   ease_ready;
    ease_t  ease_data;
    rgb_t   rgb;

    assign tick.now_ms    = s_tdata[31:0];
    assign tick.severity  = s_tdata[34:32];
    assign tick.night     = s_tdata[35];
    assign tick.blackout  = s_tdata[36];
    assign tick.force_off = s_tdata[37];

    sbc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sbc_phase u_phase (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_tick   (tick),
        .out_valid (ph_valid),
        .out_ready (ph_ready),
        .out_phase (ph_data)
    );

    sbc_ease_rom u_rom (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ph_valid),
        .in_ready  (ph_ready),
        .in_phase  (ph_data),
        .out_valid (ease_valid),
        .out_ready (ease_ready),
        .out_ease  (ease_data)
    );

    sbc_level u_level (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ease_valid),
        .in_ready  (ease_ready),
        .in_ease   (ease_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rgb   (rgb)
    );

    assign m_tdata = {rgb.blue, rgb.green, rgb.red};

`ifndef SYNTH
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        ph_valid |-> (ph_data.idx <= IDX_W'(EASE_N)))
        else $error("ease index beyond table");

    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ph_valid && !ph_ready) |=> (ph_valid && $stable(ph_data)))
        else $error("phase output changed while stalled");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input blocked without output stall");
`endif

endmodule

`default_nettype wire

/* src/sbc_cfg.sv */
`default_nettype none

module sbc_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sbc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output sbc_pkg::cfg_t                  cfg
);
    import sbc_pkg::*;

    logic        enable_reg;
    logic [15:0] day_gain_reg;
    logic [15:0] night_gain_reg;
    logic [1:0]  reg_idx;
    logic        wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b0;
            day_gain_reg   <= DAY_GAIN_RST;
            night_gain_reg <= NIGHT_GAIN_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                CFG_IDX_ENABLE: enable_reg     <= pwdata[0];
                CFG_IDX_DAY:    day_gain_reg   <= pwdata[15:0];
                CFG_IDX_NIGHT:  night_gain_reg <= pwdata[15:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            CFG_IDX_ENABLE: prdata = {31'd0, enable_reg};
            CFG_IDX_DAY:    prdata = {16'd0, day_gain_reg};
            CFG_IDX_NIGHT:  prdata = {16'd0, night_gain_reg};
            default:        prdata = 32'd0;
        endcase
    end

    assign cfg.enable     = enable_reg;
    assign cfg.day_gain   = day_gain_reg;
    assign cfg.night_gain = night_gain_reg;

endmodule

`default_nettype wire

/* src/sbc_phase.sv */
`default_nettype none

module sbc_phase (
    input  logic            clk,
    input  logic            rst_n,
    input  sbc_pkg::cfg_t   cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  sbc_pkg::tick_t  in_tick,
    output logic            out_valid,
    input  logic            out_ready,
    output sbc_pkg::phase_t out_phase
);
    import sbc_pkg::*;

    localparam int NUM_STAGES = 4;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES:0]   rdy;

    // stage 1: decode, coarse quotient of now / P
    logic [2:0]       sev;
    logic [1:0]       cls1_next;
    side_t            side1_next;
    logic [63:0]      mod_prod;
    logic [MOD_W-1:0] q1_next;
    logic [MOD_W-1:0] q1_reg;
    logic [MOD_W-1:0] now1_reg;
    logic [1:0]       cls1_reg;
    side_t            side1_reg;

    // stage 2: remainder estimate, 0 .. 2P-1
    logic [2*MOD_W-1:0] qp;
    logic [MOD_W-1:0]   r2_next;
    logic [MOD_W-1:0]   r2_reg;
    logic [1:0]         cls2_reg;
    side_t              side2_reg;

    // stage 3: final remainder, triangle fold
    logic [MOD_W-1:0]  r_fix;
    logic [HALF_W-1:0] t3_next;
    logic [HALF_W-1:0] t3_reg;
    logic [1:0]        cls3_reg;
    side_t             side3_reg;

    // stage 4: table index
    logic [IDX_PROD_W-1:0] idx_prod;
    logic [IDX_W-1:0]      idx4_next;
    logic [IDX_W-1:0]      idx4_reg;
    side_t                 side4_reg;

    always_comb
    begin
        rdy[NUM_STAGES] = out_ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--)
            rdy[k] = !valid_reg[k] || rdy[k+1];
    end

    assign in_ready   = rdy[0];
    assign valid_next = {valid_reg[NUM_STAGES-2:0], in_valid && cfg.enable};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            for (int k = 0; k < NUM_STAGES; k++)
                if (rdy[k])
                    valid_reg[k] <= valid_next[k];
        end
    end

    always_comb
    begin
        sev = (in_tick.severity > SEV_TAMPER) ? SEV_TAMPER : in_tick.severity;
        if (sev >= SEV_ALERT)
            cls1_next = CLS_ALERT;
        else if (sev == SEV_WARN)
            cls1_next = CLS_WARN;
        else
            cls1_next = CLS_CALM;

        side1_next.black = in_tick.blackout || in_tick.force_off;
        side1_next.attn  = (sev >= SEV_WARN);
        side1_next.peak  = in_tick.night ? cfg.night_gain : cfg.day_gain;
        if (in_tick.night)
            side1_next.hue = (sev >= SEV_ALERT) ? HUE_NIGHT_ALERT : HUE_NIGHT_CALM;
        else if (sev == SEV_WARN)
            side1_next.hue = HUE_DAY_WARN;
        else if (sev >= SEV_ALERT)
            side1_next.hue = HUE_DAY_ALERT;
        else
            side1_next.hue = HUE_DAY_CALM;

        mod_prod = 64'(in_tick.now_ms) * 64'(mod_recip(cls1_next));
        q1_next  = mod_prod[MOD_SHIFT +: MOD_W];
    end

    // only the low bits matter: the remainder is below 2^MOD_W
    always_comb
    begin
        qp      = (2*MOD_W)'(q1_reg) * (2*MOD_W)'(full_period(cls1_reg));
        r2_next = now1_reg - qp[MOD_W-1:0];
    end

    always_comb
    begin
        r_fix = (r2_reg >= full_period(cls2_reg)) ? r2_reg - full_period(cls2_reg) : r2_reg;
        if (r_fix < MOD_W'(half_period(cls2_reg)))
            t3_next = HALF_W'(r_fix);
        else
            t3_next = HALF_W'(full_period(cls2_reg) - r_fix);
    end

    always_comb
    begin
        idx_prod  = IDX_PROD_W'(t3_reg) * IDX_PROD_W'(idx_recip(cls3_reg));
        idx4_next = idx_prod[IDX_SHIFT +: IDX_W];
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            q1_reg    <= q1_next;
            now1_reg  <= in_tick.now_ms[MOD_W-1:0];
            cls1_reg  <= cls1_next;
            side1_reg <= side1_next;
        end
        if (rdy[1])
        begin
            r2_reg    <= r2_next;
            cls2_reg  <= cls1_reg;
            side2_reg <= side1_reg;
        end
        if (rdy[2])
        begin
            t3_reg    <= t3_next;
            cls3_reg  <= cls2_reg;
            side3_reg <= side2_reg;
        end
        if (rdy[3])
        begin
            idx4_reg  <= idx4_next;
            side4_reg <= side3_reg;
        end
    end

    assign out_valid      = valid_reg[NUM_STAGES-1];
    assign out_phase.idx  = idx4_reg;
    assign out_phase.side = side4_reg;

endmodule

`default_nettype wire

/* src/sbc_ease_rom.sv */
`default_nettype none

module sbc_ease_rom (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  sbc_pkg::phase_t in_phase,
    output logic            out_valid,
    input  logic            out_ready,
    output sbc_pkg::ease_t  out_ease
);
    import sbc_pkg::*;

    logic [15:0] rom [0:EASE_N];
    logic        valid_reg;
    logic [15:0] ease_reg;
    side_t       side_reg;

    for (genvar g = 0; g <= EASE_N; g++)
    begin : g_rom
        localparam logic [15:0] EntryValue = ease_value(g);
        assign rom[g] = EntryValue;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            ease_reg <= rom[in_phase.idx];
            side_reg <= in_phase.side;
        end
    end

    assign out_valid      = valid_reg;
    assign out_ease.ease  = ease_reg;
    assign out_ease.side  = side_reg;

endmodule

`default_nettype wire

/* src/sbc_level.sv */
`default_nettype none

module sbc_level (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  sbc_pkg::ease_t in_ease,
    output logic           out_valid,
    input  logic           out_ready,
    output sbc_pkg::rgb_t  out_rgb
);
    import sbc_pkg::*;

    localparam int NUM_STAGES = 3;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES:0]   rdy;

    // stage 1: floor + eased share
    logic [31:0] share_prod;
    logic [15:0] mix1_next;
    logic [15:0] mix1_reg;
    logic        black1_reg;
    logic [15:0] peak1_reg;
    rgb_t        hue1_reg;

    // stage 2: level
    logic [31:0] level_prod;
    logic [15:0] level2_next;
    logic [15:0] level2_reg;
    logic        black2_reg;
    rgb_t        hue2_reg;

    // stage 3: channels
    logic [23:0] red_prod;
    logic [23:0] green_prod;
    logic [23:0] blue_prod;
    rgb_t        rgb3_next;
    rgb_t        rgb3_reg;

    always_comb
    begin
        rdy[NUM_STAGES] = out_ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--)
            rdy[k] = !valid_reg[k] || rdy[k+1];
    end

    assign in_ready   = rdy[0];
    assign valid_next = {valid_reg[NUM_STAGES-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            for (int k = 0; k < NUM_STAGES; k++)
                if (rdy[k])
                    valid_reg[k] <= valid_next[k];
        end
    end

    // floor + share stays below 2^16
    always_comb
    begin
        share_prod = 32'(in_ease.side.attn ? FLOOR_ATTN_INV : FLOOR_CALM_INV) * 32'(in_ease.ease);
        mix1_next  = 16'(17'(in_ease.side.attn ? FLOOR_ATTN : FLOOR_CALM)
                         + 17'(share_prod[31:16]));
    end

    always_comb
    begin
        level_prod  = 32'(peak1_reg) * 32'(mix1_reg);
        level2_next = level_prod[31:16];
    end

    always_comb
    begin
        red_prod   = 24'(hue2_reg.red)   * 24'(level2_reg);
        green_prod = 24'(hue2_reg.green) * 24'(level2_reg);
        blue_prod  = 24'(hue2_reg.blue)  * 24'(level2_reg);
        if (black2_reg)
            rgb3_next = '0;
        else
        begin
            rgb3_next.red   = red_prod[23:16];
            rgb3_next.green = green_prod[23:16];
            rgb3_next.blue  = blue_prod[23:16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            mix1_reg   <= mix1_next;
            black1_reg <= in_ease.side.black;
            peak1_reg  <= in_ease.side.peak;
            hue1_reg   <= in_ease.side.hue;
        end
        if (rdy[1])
        begin
            level2_reg <= level2_next;
            black2_reg <= black1_reg;
            hue2_reg   <= hue1_reg;
        end
        if (rdy[2])
            rgb3_reg <= rgb3_next;
    end

    assign out_valid = valid_reg[NUM_STAGES-1];
    assign out_rgb   = rgb3_reg;

endmodule

`default_nettype wire
